### src/lvcd_pkg.sv
// Package for the label vote change detector.
// Holds field widths, the action codes and the structs passed between modules.
// No dependencies.
`default_nettype none

package lvcd_pkg;

   // Field widths fixed by the interface.
   localparam int LABEL_W  = 4;
   localparam int CONF_W   = 16;
   localparam int COUNT_W  = 16;
   localparam int SUM_W    = 32;
   localparam int ACTION_W = 2;

   // Largest label value the label field can carry, plus one.
   localparam int LABEL_SPAN = 1 << LABEL_W;

   // Action reported with each closed frame.
   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE = 2'd0,
      ACT_STOP = 2'd1,
      ACT_SLOW = 2'd2
   } action_type;

   // Command from the frame stage to the histogram.
   typedef struct packed {
      logic               hit;    // count this label
      logic               clear;  // frame closes: wipe histogram and leader
      logic [LABEL_W-1:0] label;
   } hist_cmd_type;

   // Running leader of the histogram.
   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [COUNT_W-1:0] count;
   } leader_type;

endpackage

`default_nettype wire

### src/lvcd_hist.sv
// Label histogram with a running leader (most frequent label, smallest on ties).
// Depends on lvcd_pkg for widths and the command and leader structs.
// Counts saturate and are all wiped at once when a frame closes.
`default_nettype none

module lvcd_hist #(
   parameter int NUM_CLASSES = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lvcd_pkg::hist_cmd_type cmd,
   output lvcd_pkg::leader_type      leader_next
);

   // Only labels the label field can express ever reach a bin.
   localparam int DEPTH = (NUM_CLASSES < lvcd_pkg::LABEL_SPAN) ?
                          NUM_CLASSES : lvcd_pkg::LABEL_SPAN;
   localparam int IDX_W = $clog2(DEPTH);

   logic [lvcd_pkg::COUNT_W-1:0] counts_ff [DEPTH];
   logic [lvcd_pkg::COUNT_W-1:0] count_in;
   logic [lvcd_pkg::COUNT_W-1:0] cur_count;
   logic [lvcd_pkg::LABEL_W-1:0] leader_label_ff;
   logic [lvcd_pkg::COUNT_W-1:0] leader_count_ff;
   logic [IDX_W-1:0]             idx;
   logic                         take_lead;

   // Read the bin, bump it with saturation and test it against the leader.
   always_comb begin
      idx       = cmd.label[IDX_W-1:0];
      cur_count = counts_ff[idx];
      count_in  = (cur_count == '1) ? cur_count : cur_count + 1'b1;
      take_lead = (count_in > leader_count_ff) ||
                  ((count_in == leader_count_ff) && (cmd.label < leader_label_ff));
      if (cmd.hit && take_lead) begin
         leader_next.label = cmd.label;
         leader_next.count = count_in;
      end else begin
         leader_next.label = leader_label_ff;
         leader_next.count = leader_count_ff;
      end
   end

   // Bins and leader; a closing frame wipes everything at once.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < DEPTH; i++) begin
            counts_ff[i] <= '0;
         end
         leader_label_ff <= '0;
         leader_count_ff <= '0;
      end else if (cmd.hit) begin
         counts_ff[idx]  <= count_in;
         leader_label_ff <= leader_next.label;
         leader_count_ff <= leader_next.count;
      end
   end

endmodule

`default_nettype wire

### src/label_vote_change_detector_core.sv
// Top level of the label vote change detector: frame stage, mean test and result register.
// Depends on lvcd_pkg and lvcd_hist.
`default_nettype none

// The block takes one classifier request per clock cycle (label, confidence, frame_end)
// and returns one response for each request that carries frame_end: the dominant label
// of the frame (smallest on ties) and an action. The first frame after reset only
// records its dominant label and reports no action. Later frames report stop when the
// mean confidence is at or below csr_min_confidence, otherwise slow down when the
// dominant label differs from the recorded one. A request is held in an input register
// while the histogram bin is read, bumped and compared with the running leader; a
// closing request then loads the response register. Requests flow at one per cycle
// except while the input side stalls, which happens only while a frame-closing
// request waits for the response register to empty. Requests beyond MAX_FRAME in
// one frame are ignored except that their frame_end still closes the frame.
// Write csr_min_confidence only while no request is in flight.
module label_vote_change_detector_core #(
   parameter int NUM_CLASSES = 16,
   parameter int MAX_FRAME   = 65535
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [lvcd_pkg::LABEL_W-1:0]  req_class_label,
   input  wire logic [lvcd_pkg::CONF_W-1:0]   req_confidence,
   input  wire logic                          req_frame_end,
   // Response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [lvcd_pkg::ACTION_W-1:0]      rsp_action,
   output logic [lvcd_pkg::LABEL_W-1:0]       rsp_dominant_class,
   // Threshold register write
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [lvcd_pkg::CONF_W-1:0]   csr_min_confidence
);

   localparam int ELEM_W = $clog2(MAX_FRAME + 1);
   localparam int PROD_W = lvcd_pkg::CONF_W + ELEM_W;
   localparam int CMP_W  = (PROD_W > lvcd_pkg::SUM_W) ? PROD_W : lvcd_pkg::SUM_W;
   localparam logic [ELEM_W-1:0] MAX_CNT = ELEM_W'(MAX_FRAME);

   // Threshold register
   logic [lvcd_pkg::CONF_W-1:0]  min_conf_ff;

   // Input register
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic [lvcd_pkg::LABEL_W-1:0] s1_label_ff;
   logic [lvcd_pkg::CONF_W-1:0]  s1_conf_ff;
   logic                         s1_end_ff;

   // Frame accumulators
   logic [lvcd_pkg::SUM_W-1:0]   sum_ff;
   logic [lvcd_pkg::SUM_W-1:0]   sum_in;
   logic [ELEM_W-1:0]            elem_ff;
   logic [ELEM_W-1:0]            elem_in;
   logic [lvcd_pkg::LABEL_W-1:0] last_dom_ff;
   logic [lvcd_pkg::LABEL_W-1:0] last_dom_in;
   logic                         last_valid_ff;
   logic                         last_valid_in;

   // Result register
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   lvcd_pkg::action_type         rsp_action_ff;
   lvcd_pkg::action_type         action_in;
   logic [lvcd_pkg::LABEL_W-1:0] rsp_dom_ff;

   // Stage working signals
   logic                         s1_go;
   logic                         req_take;
   logic                         counted;
   logic                         in_range;
   logic [lvcd_pkg::SUM_W:0]     sum_add;
   logic [lvcd_pkg::SUM_W-1:0]   sum_fin;
   logic [ELEM_W-1:0]            elem_fin;
   logic [PROD_W-1:0]            limit;
   logic                         low_conf;
   lvcd_pkg::hist_cmd_type       hist_cmd;
   lvcd_pkg::leader_type         leader_next;

   // Handshakes: the stage moves unless a closing request cannot reach the result register.
   always_comb begin
      s1_go     = s1_valid_ff && !(s1_end_ff && rsp_valid_ff && rsp_stall);
      req_stall = s1_valid_ff && !s1_go;
      req_take  = req_valid && !req_stall;
      csr_ready = 1'b1;
   end

   // Threshold register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_conf_ff <= lvcd_pkg::CONF_W'(32768);
      end else if (csr_valid && csr_ready) begin
         min_conf_ff <= csr_min_confidence;
      end
   end

   // Input register.
   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !s1_go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_label_ff <= req_class_label;
         s1_conf_ff  <= req_confidence;
         s1_end_ff   <= req_frame_end;
      end
   end

   // Element counting with saturating confidence sum.
   always_comb begin
      counted  = (elem_ff < MAX_CNT);
      in_range = (int'(s1_label_ff) < NUM_CLASSES);
      sum_add  = {1'b0, sum_ff} + (lvcd_pkg::SUM_W + 1)'(s1_conf_ff);
      if (counted) begin
         sum_fin  = sum_add[lvcd_pkg::SUM_W] ? '1 : sum_add[lvcd_pkg::SUM_W-1:0];
         elem_fin = elem_ff + 1'b1;
      end else begin
         sum_fin  = sum_ff;
         elem_fin = elem_ff;
      end
      hist_cmd.hit   = s1_go && counted && in_range;
      hist_cmd.clear = s1_go && s1_end_ff;
      hist_cmd.label = s1_label_ff;
      if (s1_go && s1_end_ff) begin
         sum_in  = '0;
         elem_in = '0;
      end else if (s1_go) begin
         sum_in  = sum_fin;
         elem_in = elem_fin;
      end else begin
         sum_in  = sum_ff;
         elem_in = elem_ff;
      end
   end

   lvcd_hist #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_hist (
      .clock       (clock),
      .reset       (reset),
      .cmd         (hist_cmd),
      .leader_next (leader_next)
   );

   // Exact mean test: sum <= threshold * element count.
   always_comb begin
      limit    = PROD_W'(min_conf_ff) * PROD_W'(elem_fin);
      low_conf = (CMP_W'(sum_fin) <= CMP_W'(limit));
   end

   // Frame decision and recorded dominant label.
   always_comb begin
      action_in     = lvcd_pkg::ACT_NONE;
      last_dom_in   = last_dom_ff;
      last_valid_in = last_valid_ff;
      if (s1_go && s1_end_ff) begin
         if (!last_valid_ff) begin
            last_dom_in   = leader_next.label;
            last_valid_in = 1'b1;
         end else if (low_conf) begin
            action_in = lvcd_pkg::ACT_STOP;
         end else if (leader_next.label != last_dom_ff) begin
            action_in   = lvcd_pkg::ACT_SLOW;
            last_dom_in = leader_next.label;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         elem_ff       <= '0;
         last_dom_ff   <= '0;
         last_valid_ff <= 1'b0;
      end else begin
         sum_ff        <= sum_in;
         elem_ff       <= elem_in;
         last_dom_ff   <= last_dom_in;
         last_valid_ff <= last_valid_in;
      end
   end

   // Result register: loaded by a closing request, emptied when taken.
   always_comb begin
      if (s1_go && s1_end_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_end_ff) begin
         rsp_action_ff <= action_in;
         rsp_dom_ff    <= leader_next.label;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_dominant_class = rsp_dom_ff;

`ifndef SYNTHESIS
   // The input side stalls only behind a closing request blocked at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_end_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked closing request");

   // A closed frame leaves the accumulators empty.
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_end_ff) |=> (sum_ff == '0 && elem_ff == '0))
      else $error("accumulators not cleared after frame end");

   // A pending slow-down always matches the recorded dominant label.
   a_slow_recorded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_action_ff == lvcd_pkg::ACT_SLOW) |->
      (rsp_dom_ff == last_dom_ff))
      else $error("slow-down response does not match recorded label");

   // Any action needs an earlier recorded frame.
   a_action_after_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_action_ff != lvcd_pkg::ACT_NONE) |-> last_valid_ff)
      else $error("action reported before a first frame was recorded");
`endif

endmodule

`default_nettype wire
